/* hw/rtl/rhe_pkg.sv */
// ----------------------------------------------------------------------------
// rhe_pkg
// Types and constants shared by the RGB histogram equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rhe_pkg;

   // Histogram and table geometry.
   localparam int LEVELS     = 256;
   localparam int LEVEL_BITS = 8;
   localparam int NUM_CH     = 3;
   localparam int CH_BITS    = 2;

   // Configuration registers: 13-bit width and height, 26-bit pixel total.
   localparam int REG_W      = 13;
   localparam int TOT_W      = 2 * REG_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [LEVEL_BITS-1:0] MAX_LEVEL = 8'd255;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1
   } csr_idx_type;

   // Item commands.
   typedef enum logic [1:0] {
      CMD_COUNT = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_MAP   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_BLD_START,
      ST_BLD_RD,
      ST_BLD_ACC,
      ST_BLD_NUM,
      ST_BLD_MUL,
      ST_BLD_SUB,
      ST_BLD_SAT,
      ST_BLD_DIV,
      ST_BLD_WR,
      ST_MAP_RD,
      ST_MAP_OUT
   } state_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [LEVEL_BITS-1:0] red_in;
      logic [LEVEL_BITS-1:0] green_in;
      logic [LEVEL_BITS-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] red_out;
      logic [LEVEL_BITS-1:0] green_out;
      logic [LEVEL_BITS-1:0] blue_out;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/rgb_histogram_equalizer.sv */
// ----------------------------------------------------------------------------
// rgb_histogram_equalizer
// Per-channel histogram equalization of RGB pixels with one shared
// shift-add and compare-subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// Count and map items hold the block while they run; a map result is registered
// from the table read once the output register is free. Clear runs a pass that
// writes zero into every bin of the three histograms. Build walks 3 x 256 bins;
// each table entry is formed by the 8-step restoring divider. One item is taken
// at a time; reset sets width and height to 1 and starts the clear pass.
`default_nettype none

module rgb_histogram_equalizer
   import rhe_pkg::*;
#(
   parameter int COUNT_BITS = 25
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire req_type              req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   localparam int CDF_W = COUNT_BITS + LEVEL_BITS;
   localparam int DIV_W = CDF_W + 10;
   localparam int CMP_W = (COUNT_BITS > TOT_W) ? COUNT_BITS : TOT_W;
   localparam int DSR_W = TOT_W + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Control and datapath registers.
   state_type               state_ff, state_in;
   logic [REG_W-1:0]        width_ff, height_ff;
   logic [LEVEL_BITS-1:0]   pix_ff [NUM_CH];
   logic [CH_BITS-1:0]      ch_ff;
   logic [LEVEL_BITS-1:0]   bin_ff;
   logic [TOT_W-1:0]        total_ff;
   logic [COUNT_BITS-1:0]   first_ff;
   logic [CDF_W-1:0]        cdf_ff;
   logic [CDF_W-1:0]        num_ff;
   logic [DSR_W-1:0]        dsr_ff;
   logic                    pos_ff;
   logic [DIV_W-1:0]        rem_ff;
   logic [2:0]              k_ff;
   logic [LEVEL_BITS-1:0]   q_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff;

   // Histogram memories and table memories.
   logic [COUNT_BITS-1:0]   cnt_mem [NUM_CH][LEVELS];
   logic [COUNT_BITS-1:0]   cnt_rd_ff [NUM_CH];
   logic [LEVEL_BITS-1:0]   tbl_mem [NUM_CH][LEVELS];
   logic [LEVEL_BITS-1:0]   tbl_rd_ff [NUM_CH];

   // Control outputs of the sequencer.
   logic                    accept;
   logic                    load_rsp;
   logic                    clr_we;
   logic                    cnt_we;
   logic                    tbl_we;

   logic [LEVEL_BITS-1:0]   cnt_addr [NUM_CH];
   logic [COUNT_BITS-1:0]   cnt_val [NUM_CH];
   logic [COUNT_BITS-1:0]   bin_val;
   logic [DIV_W-1:0]        dsr_ext;
   logic [DIV_W-1:0]        dsr_sh;
   logic [DIV_W-1:0]        dsr_top;
   logic [CMP_W-1:0]        den_full;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.cmd)
                  CMD_COUNT: state_in = ST_CNT_RD;
                  CMD_BUILD: state_in = ST_BLD_START;
                  CMD_MAP:   state_in = ST_MAP_RD;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR:     state_in = (bin_ff == MAX_LEVEL) ? ST_IDLE : ST_CLEAR;
         ST_CNT_RD:    state_in = ST_CNT_WR;
         ST_CNT_WR:    state_in = ST_IDLE;
         ST_BLD_START: state_in = ST_BLD_RD;
         ST_BLD_RD:    state_in = ST_BLD_ACC;
         ST_BLD_ACC:   state_in = ST_BLD_NUM;
         ST_BLD_NUM:   state_in = (CMP_W'(total_ff) > CMP_W'(first_ff)) ? ST_BLD_MUL
                                                                         : ST_BLD_WR;
         ST_BLD_MUL:   state_in = ST_BLD_SUB;
         ST_BLD_SUB:   state_in = ST_BLD_SAT;
         ST_BLD_SAT:   state_in = (rem_ff >= dsr_top) ? ST_BLD_WR : ST_BLD_DIV;
         ST_BLD_DIV:   state_in = (k_ff == 3'd0) ? ST_BLD_WR : ST_BLD_DIV;
         ST_BLD_WR: begin
            if (bin_ff == MAX_LEVEL && ch_ff == CH_BITS'(NUM_CH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_BLD_RD;
            end
         end
         ST_MAP_RD:    state_in = ST_MAP_OUT;
         ST_MAP_OUT:   state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_MAP_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      accept     = req_valid && req_ready;
      clr_we     = (state_ff == ST_CLEAR);
      cnt_we     = (state_ff == ST_CNT_WR);
      tbl_we     = (state_ff == ST_BLD_WR);
      load_rsp   = (state_ff == ST_MAP_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   // Shared datapath helpers.
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         cnt_addr[c] = (state_ff == ST_BLD_RD) ? bin_ff : pix_ff[c];
         cnt_val[c]  = cnt_rd_ff[c];
      end
      case (ch_ff)
         2'd0:    bin_val = cnt_val[0];
         2'd1:    bin_val = cnt_val[1];
         default: bin_val = cnt_val[2];
      endcase
      dsr_ext  = DIV_W'(dsr_ff);
      dsr_sh   = dsr_ext << k_ff;
      dsr_top  = dsr_ext << LEVEL_BITS;
      den_full = CMP_W'(total_ff) - CMP_W'(first_ff);
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   // Control registers. Reset starts the histogram clear pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         width_ff     <= REG_W'(1);
         height_ff    <= REG_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   // Histogram memories: one registered read and one write per channel.
   // The clear pass writes zero into one bin per cycle.
   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CH; c++) begin
         cnt_rd_ff[c] <= cnt_mem[c][cnt_addr[c]];
         if (clr_we) begin
            cnt_mem[c][bin_ff] <= '0;
         end else if (cnt_we) begin
            cnt_mem[c][pix_ff[c]] <= (cnt_val[c] == COUNT_MAX) ? cnt_val[c]
                                                                : cnt_val[c] + 1'b1;
         end
      end
   end

   // Table memories: written during build, read for map.
   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CH; c++) begin
         tbl_rd_ff[c] <= tbl_mem[c][pix_ff[c]];
         if (tbl_we && ch_ff == CH_BITS'(c)) begin
            tbl_mem[c][bin_ff] <= q_ff;
         end
      end
   end

   // Item capture, the clear pass counter and the build datapath.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff[0] <= req_data.red_in;
         pix_ff[1] <= req_data.green_in;
         pix_ff[2] <= req_data.blue_in;
      end
      if (reset) begin
         bin_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               bin_ff <= '0;
            end
            ST_CLEAR: begin
               bin_ff <= bin_ff + 1'b1;
            end
            ST_BLD_START: begin
               total_ff <= TOT_W'(width_ff) * TOT_W'(height_ff);
               ch_ff    <= '0;
               bin_ff   <= '0;
               cdf_ff   <= '0;
            end
            ST_BLD_ACC: begin
               cdf_ff <= cdf_ff + CDF_W'(bin_val);
               if (bin_ff == '0) begin
                  first_ff <= bin_val;
               end
            end
            ST_BLD_NUM: begin
               num_ff <= cdf_ff - CDF_W'(first_ff);
               dsr_ff <= {TOT_W'(den_full), 1'b0};
               pos_ff <= CMP_W'(total_ff) > CMP_W'(first_ff);
               q_ff   <= '0;
            end
            // 510 * num + den, formed as (num << 9) + den - (num << 1).
            ST_BLD_MUL: begin
               rem_ff <= (DIV_W'(num_ff) << 9) + DIV_W'(dsr_ff[DSR_W-1:1]);
            end
            ST_BLD_SUB: begin
               rem_ff <= rem_ff - (DIV_W'(num_ff) << 1);
            end
            ST_BLD_SAT: begin
               k_ff <= 3'd7;
               if (rem_ff >= dsr_top) begin
                  q_ff <= MAX_LEVEL;
               end
            end
            // One restoring division step per cycle.
            ST_BLD_DIV: begin
               if (rem_ff >= dsr_sh) begin
                  rem_ff <= rem_ff - dsr_sh;
                  q_ff   <= {q_ff[LEVEL_BITS-2:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[LEVEL_BITS-2:0], 1'b0};
               end
               k_ff <= k_ff - 3'd1;
            end
            ST_BLD_WR: begin
               bin_ff <= bin_ff + 1'b1;
               if (bin_ff == MAX_LEVEL) begin
                  ch_ff  <= ch_ff + 1'b1;
                  cdf_ff <= '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (load_rsp) begin
         rsp_data_ff.red_out   <= tbl_rd_ff[0];
         rsp_data_ff.green_out <= tbl_rd_ff[1];
         rsp_data_ff.blue_out  <= tbl_rd_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result appears only out of the map output state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MAP_OUT))
      else $error("result raised outside a map item");

   // The divider remainder stays below twice the current shifted divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD_DIV) |-> (rem_ff < (dsr_ext << ({1'b0, k_ff} + 4'd1))))
      else $error("divider remainder out of range");

   // A zero denominator yields a zero table entry.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD_WR && !pos_ff) |-> (q_ff == '0))
      else $error("entry not zero for empty denominator");

   // An accepted map item goes on to read the tables.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.cmd == CMD_MAP) |=> (state_ff == ST_MAP_RD))
      else $error("map item did not start a table read");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the RGB histogram equalizer. The bench counts pixels, builds the
// tables, maps pixels and compares each mapped pixel with its own model of
// the histograms and tables. Both channel sides stall at random.
// ----------------------------------------------------------------------------
module tb_top
   import rhe_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_BITS = 25;
   localparam longint BIN_MAX = (64'd1 << COUNT_BITS) - 1;
   // Register indexes past the last register; the block ignores these writes.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   // Wait long enough for the longest build to finish, with margin.
   localparam int BUILD_SETTLE = 12500;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;

   // Model state of the equalizer.
   longint      hist [3][LEVELS];
   logic [7:0]  lut [3][LEVELS];
   longint      img_width = 1;
   longint      img_height = 1;

   rsp_type     pending_pixels [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          errors = 0;
   int          items_sent = 0;
   int          pixels_mapped = 0;
   int          builds_done = 0;

   rgb_histogram_equalizer #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Receiver side stalls at the current idle rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each mapped pixel with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_mapped++;
            if (want.red_out !== rsp_data.red_out) begin
               $display("%0t: red exp %0d got %0d", $time, want.red_out, rsp_data.red_out);
               errors++;
            end
            if (want.green_out !== rsp_data.green_out) begin
               $display("%0t: green exp %0d got %0d", $time, want.green_out,
                        rsp_data.green_out);
               errors++;
            end
            if (want.blue_out !== rsp_data.blue_out) begin
               $display("%0t: blue exp %0d got %0d", $time, want.blue_out, rsp_data.blue_out);
               errors++;
            end
         end
      end
   end

   // Walk the bins of every channel and form the equalization tables.
   function automatic void build_luts();
      longint total, cdf, num, den, v;
      total = img_width * img_height;
      for (int ch = 0; ch < 3; ch++) begin
         cdf = 0;
         for (int i = 0; i < LEVELS; i++) begin
            cdf += hist[ch][i];
            v = 0;
            if (total > hist[ch][0]) begin
               den = total - hist[ch][0];
               num = cdf - hist[ch][0];
               v = (2 * 255 * num + den) / (2 * den);
               if (v > 255) v = 255;
            end
            lut[ch][i] = v[7:0];
         end
      end
      builds_done++;
   endfunction

   // Update the model for one accepted item.
   function automatic void predict_item(req_type it);
      logic [7:0] lv [3];
      rsp_type px;
      lv[0] = it.red_in;
      lv[1] = it.green_in;
      lv[2] = it.blue_in;
      case (it.cmd)
         CMD_COUNT: begin
            for (int ch = 0; ch < 3; ch++)
               if (hist[ch][lv[ch]] < BIN_MAX) hist[ch][lv[ch]]++;
         end
         CMD_BUILD: build_luts();
         CMD_MAP: begin
            px.red_out = lut[0][lv[0]];
            px.green_out = lut[1][lv[1]];
            px.blue_out = lut[2][lv[2]];
            pending_pixels.push_back(px);
         end
         default: begin
            foreach (hist[ch, i]) hist[ch][i] = 0;
         end
      endcase
   endfunction

   // Offer one item, wait for it to be taken, then maybe leave a gap.
   task automatic send_item(cmd_type c, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_type it;
      it.cmd = c;
      it.red_in = r;
      it.green_in = g;
      it.blue_in = b;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      predict_item(it);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic send_pixel(cmd_type c);
      send_item(c, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
   endtask

   // Let the block drain, then write one register.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (BUILD_SETTLE) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[REG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WIDTH) img_width = longint'(val[REG_W-1:0]);
      else if (idx == CSR_HEIGHT) img_height = longint'(val[REG_W-1:0]);
   endtask

   task automatic set_size(int unsigned w, int unsigned h);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   // One pixel image holding more pixels than its size: entries saturate, and
   // a channel whose first bin holds them all has a zero denominator.
   task automatic test_overfull_image();
      set_size(1, 1);
      send_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
      send_item(CMD_COUNT, 8'd0, 8'd255, 8'd128);
      send_item(CMD_COUNT, 8'd0, 8'd1, 8'd128);
      send_item(CMD_COUNT, 8'd0, 8'd254, 8'd0);
      send_item(CMD_BUILD, 8'd0, 8'd0, 8'd0);
      send_item(CMD_MAP, 8'd0, 8'd0, 8'd0);
      send_item(CMD_MAP, 8'd255, 8'd255, 8'd255);
      send_item(CMD_MAP, 8'd128, 8'd1, 8'd127);
   endtask

   // Small image filled exactly, then a 4096 x 4096 image, with level extremes.
   task automatic test_level_extremes();
      set_size(2, 2);
      send_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
      send_item(CMD_COUNT, 8'd0, 8'd255, 8'd85);
      send_item(CMD_COUNT, 8'd255, 8'd0, 8'd170);
      send_item(CMD_COUNT, 8'd170, 8'd85, 8'd255);
      send_item(CMD_COUNT, 8'd85, 8'd170, 8'd0);
      send_item(CMD_BUILD, 8'd0, 8'd0, 8'd0);
      send_item(CMD_MAP, 8'd255, 8'd0, 8'd85);
      send_item(CMD_MAP, 8'd0, 8'd255, 8'd170);
      set_size(4096, 4096);
      write_reg(CSR_SPARE_A, 32'h1555);
      write_reg(CSR_SPARE_B, 32'h0AAA);
      send_item(CMD_COUNT, 8'd255, 8'd255, 8'd255);
      send_item(CMD_COUNT, 8'd0, 8'd0, 8'd0);
      send_item(CMD_BUILD, 8'd0, 8'd0, 8'd0);
      send_item(CMD_MAP, 8'd255, 8'd128, 8'd0);
      send_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
      send_item(CMD_MAP, 8'd1, 8'd254, 8'd255);
   endtask

   // Frames of clear, count, build and map at a random image size, with
   // stray commands mixed in.
   task automatic test_random_frames(int target);
      int stop_at, n_count, n_map, pick;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(4) == 0)
            set_size($urandom_range(4096, 1), $urandom_range(4096, 1));
         else
            set_size($urandom_range(8, 1), $urandom_range(8, 1));
         if ($urandom_range(3) == 0)
            write_reg(CSR_IDX_W'(CSR_SPARE_A + $urandom_range(1)), $urandom_range(8191));
         if ($urandom_range(7) != 0) send_pixel(CMD_CLEAR);
         n_count = $urandom_range(64, 1);
         for (int i = 0; i < n_count; i++) begin
            // Bias some pixels to level zero to load the first bin.
            if ($urandom_range(5) == 0)
               send_item(CMD_COUNT, 8'd0, 8'd0, 8'($urandom_range(255)));
            else send_pixel(CMD_COUNT);
         end
         send_pixel(CMD_BUILD);
         n_map = $urandom_range(60, 10);
         for (int i = 0; i < n_map; i++) begin
            pick = $urandom_range(99);
            if (pick < 5) send_pixel(CMD_COUNT);
            else if (pick < 7) send_pixel(CMD_CLEAR);
            else send_pixel(CMD_MAP);
         end
      end
   endtask

   initial begin
      foreach (hist[ch, i]) hist[ch][i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 25;
      recv_idle_pct = 79;
      test_overfull_image();
      test_level_extremes();
      test_random_frames(630);
      send_idle_pct = 79;
      recv_idle_pct = 25;
      test_random_frames(630);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(630);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d items, ran %0d table builds and checked %0d mapped pixels",
               items_sent, builds_done, pixels_mapped);
      $display("over image sizes from 1x1 to 4096x4096 under both stall patterns.");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #20ms;
      $display("Timed out waiting for the block.");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/rhe_pkg.sv
hw/rtl/rgb_histogram_equalizer.sv
test/tb_top.sv
